[sv/hmc_pkg.sv]
// hmc_pkg: shared types and constants of the host mailbox channel
// used by the interfaces, the controller and the datapath; no dependencies
package hmc_pkg;

    // request action codes
    localparam logic [2:0] ACT_HOST_READ  = 3'd0;
    localparam logic [2:0] ACT_HOST_WRITE = 3'd1;
    localparam logic [2:0] ACT_PUSH_RESP  = 3'd2;
    localparam logic [2:0] ACT_POP_CMD    = 3'd3;
    localparam logic [2:0] ACT_TAKE_RESET = 3'd4;

    // host register offsets
    localparam logic [7:0] OFF_CMD    = 8'h40;
    localparam logic [7:0] OFF_STATUS = 8'h50;
    localparam logic [7:0] OFF_RESP   = 8'h60;

    localparam logic [7:0] STATUS_SIG = 8'hD0;
    localparam logic [7:0] ECHO_RESET = 8'hFF;

    typedef logic [2:0] action_t;
    typedef logic [7:0] byte_t;

    // controller commands to the datapath
    typedef struct packed {
        logic load_item;
        logic exec;
        logic publish;
        logic finish;
    } hmc_cmd_t;

endpackage

[sv/hmc_ifs.sv]
// hmc_ifs: valid/ready channel interfaces for requests and results
// depends on hmc_pkg
interface hmc_item_if;
    logic             valid;
    logic             ready;
    hmc_pkg::action_t action;
    hmc_pkg::byte_t   offset;
    hmc_pkg::byte_t   data;

    modport source (output valid, output action, output offset, output data, input ready);
    modport sink (input valid, input action, input offset, input data, output ready);
endinterface

interface hmc_result_if;
    logic           valid;
    logic           ready;
    hmc_pkg::byte_t result_byte;
    logic           done_res;

    modport source (output valid, output result_byte, output done_res, input ready);
    modport sink (input valid, input result_byte, input done_res, output ready);
endinterface

[sv/host_mailbox_channel.sv]
// host_mailbox_channel: byte mailbox between a host register bus and a core.
// Requests arrive on the item channel (action, offset, data): host reads and
// writes of CMD 0x40, STATUS 0x50 and RESP 0x60, core pushes of response bytes,
// core pops of command bytes and the core taking a requested soft reset.
// Every request gives exactly one result (result_byte, done_res) on the
// result channel. A request runs through three steps of the sequencer:
// execute (registers, ring or fifo write, ring read), publish (response fifo
// read) and finish (result register load), and a new request is taken only
// once the previous one has left finish. The registered reads of the
// command ring and response fifo set these steps. When the receiver stalls,
// the finished result waits in the output register and the next request is
// still accepted; it then holds in finish until the output register frees
// up. Reset clears all pointers, counters and flags, sets the CMD readback
// to 0xFF and leaves ring and fifo contents undefined.
// depends on hmc_pkg, hmc_ifs, hmc_ram, hmc_ctrl and hmc_datapath
module host_mailbox_channel #(
    parameter int CMD_DEPTH  = 64,
    parameter int RESP_DEPTH = 1024
) (
    input logic          clk,
    input logic          rst_n,
    hmc_item_if.sink     item,
    hmc_result_if.source result
);
    import hmc_pkg::*;

    hmc_cmd_t cmd;

    hmc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (item.valid),
        .in_ready  (item.ready),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .cmd       (cmd)
    );

    hmc_datapath #(
        .CMD_DEPTH  (CMD_DEPTH),
        .RESP_DEPTH (RESP_DEPTH)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .in_action   (item.action),
        .in_offset   (item.offset),
        .in_data     (item.data),
        .result_byte (result.result_byte),
        .done_res    (result.done_res)
    );

endmodule

[sv/hmc_ram.sv]
// hmc_ram: generic single write port, single read port ram with registered read
// no dependencies
module hmc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

[sv/hmc_ctrl.sv]
// hmc_ctrl: request sequencer of the host mailbox channel
// depends on hmc_pkg; drives the datapath through hmc_cmd_t
module hmc_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    output hmc_pkg::hmc_cmd_t cmd
);
    import hmc_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_EXEC = 4'b0010,
        ST_PUB  = 4'b0100,
        ST_FIN  = 4'b1000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   slot_free;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign slot_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next    = state_reg;
        cmd           = '0;
        cmd.load_item = in_valid && (state_reg == ST_IDLE);
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = ST_PUB;
            end
            ST_PUB:
            begin
                cmd.publish = 1'b1;
                state_next  = ST_FIN;
            end
            ST_FIN:
            begin
                // hold here while the previous result is still waiting
                if (slot_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.finish)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

[sv/hmc_datapath.sv]
// hmc_datapath: mailbox registers, command ring, response fifo and result register
// depends on hmc_pkg and hmc_ram; sequenced by hmc_ctrl
module hmc_datapath #(
    parameter int CMD_DEPTH  = 64,
    parameter int RESP_DEPTH = 1024
) (
    input  logic              clk,
    input  logic              rst_n,
    input  hmc_pkg::hmc_cmd_t cmd,
    input  hmc_pkg::action_t  in_action,
    input  hmc_pkg::byte_t    in_offset,
    input  hmc_pkg::byte_t    in_data,
    output hmc_pkg::byte_t    result_byte,
    output logic              done_res
);
    import hmc_pkg::*;

    localparam int CW = $clog2(CMD_DEPTH);
    localparam int RW = $clog2(RESP_DEPTH);
    localparam logic [CW-1:0] CMD_LAST  = CW'(CMD_DEPTH - 1);
    localparam logic [RW-1:0] RESP_LAST = RW'(RESP_DEPTH - 1);

    // latched request
    action_t action_reg;
    byte_t   offset_reg;
    byte_t   data_reg;

    logic [CW-1:0] cmd_head_reg, cmd_head_next;
    logic [CW-1:0] cmd_tail_reg, cmd_tail_next;
    logic [RW-1:0] resp_head_reg, resp_head_next;
    logic [RW-1:0] resp_tail_reg, resp_tail_next;
    byte_t         published_reg, published_next;
    byte_t         echo_reg, echo_next;
    logic [31:0]   ack_reg, ack_next;
    logic [31:0]   served_reg, served_next;
    logic          pending_reg, pending_next;
    logic          overflow_reg, overflow_next;
    logic          full_reg, full_next;
    logic          ready_reg, ready_next;
    logic          phase_reg, phase_next;
    logic          pub_hit_reg, pub_hit_next;
    logic          pop_reg, pop_next;
    byte_t         rb_reg, rb_next;
    logic          done_reg, done_next;
    byte_t         out_byte_reg, out_byte_next;
    logic          out_done_reg, out_done_next;

    logic [CW-1:0] cmd_head_inc, cmd_tail_inc;
    logic [RW-1:0] resp_head_inc, resp_tail_inc;
    logic          ring_we, ring_re, fifo_we, fifo_re;
    byte_t         ring_rdata, fifo_rdata;
    byte_t         status_val;

    assign cmd_head_inc  = (cmd_head_reg == CMD_LAST) ? '0 : cmd_head_reg + 1'b1;
    assign cmd_tail_inc  = (cmd_tail_reg == CMD_LAST) ? '0 : cmd_tail_reg + 1'b1;
    assign resp_head_inc = (resp_head_reg == RESP_LAST) ? '0 : resp_head_reg + 1'b1;
    assign resp_tail_inc = (resp_tail_reg == RESP_LAST) ? '0 : resp_tail_reg + 1'b1;
    assign status_val    = STATUS_SIG | {4'b0000, phase_reg, ready_reg, full_reg, overflow_reg};

    assign result_byte = out_byte_reg;
    assign done_res    = out_done_reg;

    hmc_ram #(.WIDTH(8), .DEPTH(CMD_DEPTH)) u_cmd_ring (
        .clk   (clk),
        .we    (ring_we),
        .waddr (cmd_head_reg),
        .wdata (data_reg),
        .re    (ring_re),
        .raddr (cmd_tail_reg),
        .rdata (ring_rdata)
    );

    hmc_ram #(.WIDTH(8), .DEPTH(RESP_DEPTH)) u_resp_fifo (
        .clk   (clk),
        .we    (fifo_we),
        .waddr (resp_head_reg),
        .wdata (data_reg),
        .re    (fifo_re),
        .raddr (resp_tail_reg),
        .rdata (fifo_rdata)
    );

    always_comb
    begin
        cmd_head_next  = cmd_head_reg;
        cmd_tail_next  = cmd_tail_reg;
        resp_head_next = resp_head_reg;
        resp_tail_next = resp_tail_reg;
        published_next = published_reg;
        echo_next      = echo_reg;
        ack_next       = ack_reg;
        served_next    = served_reg;
        pending_next   = pending_reg;
        overflow_next  = overflow_reg;
        full_next      = full_reg;
        ready_next     = ready_reg;
        phase_next     = phase_reg;
        pub_hit_next   = pub_hit_reg;
        pop_next       = pop_reg;
        rb_next        = rb_reg;
        done_next      = done_reg;
        out_byte_next  = out_byte_reg;
        out_done_next  = out_done_reg;
        ring_we        = 1'b0;
        ring_re        = 1'b0;
        fifo_we        = 1'b0;
        fifo_re        = 1'b0;

        if (cmd.exec)
        begin
            rb_next   = '0;
            done_next = 1'b0;
            pop_next  = 1'b0;
            case (action_reg)
                ACT_HOST_READ:
                begin
                    if (offset_reg == OFF_RESP)
                    begin
                        rb_next   = published_reg;
                        done_next = 1'b1;
                    end
                    else if (offset_reg == OFF_STATUS)
                    begin
                        rb_next   = status_val;
                        done_next = 1'b1;
                    end
                    else if (offset_reg == OFF_CMD)
                    begin
                        rb_next   = echo_reg;
                        done_next = 1'b1;
                    end
                end
                ACT_HOST_WRITE:
                begin
                    if (offset_reg == OFF_CMD)
                    begin
                        // ring keeps one slot spare
                        if (cmd_head_inc == cmd_tail_reg)
                        begin
                            full_next = 1'b1;
                        end
                        else
                        begin
                            ring_we       = 1'b1;
                            cmd_head_next = cmd_head_inc;
                        end
                        echo_next = ~data_reg;
                        done_next = 1'b1;
                    end
                    else if (offset_reg == OFF_RESP)
                    begin
                        ack_next  = ack_reg + 32'd1;
                        done_next = 1'b1;
                    end
                    else if (offset_reg == OFF_STATUS)
                    begin
                        pending_next = 1'b1;
                        done_next    = 1'b1;
                    end
                end
                ACT_PUSH_RESP:
                begin
                    if (overflow_reg || (resp_head_inc == resp_tail_reg))
                    begin
                        overflow_next = 1'b1;
                    end
                    else
                    begin
                        fifo_we        = 1'b1;
                        resp_head_next = resp_head_inc;
                        done_next      = 1'b1;
                    end
                end
                ACT_POP_CMD:
                begin
                    if (cmd_tail_reg != cmd_head_reg)
                    begin
                        ring_re       = 1'b1;
                        cmd_tail_next = cmd_tail_inc;
                        pop_next      = 1'b1;
                        done_next     = 1'b1;
                    end
                end
                ACT_TAKE_RESET:
                begin
                    if (pending_reg)
                    begin
                        resp_head_next = '0;
                        resp_tail_next = '0;
                        served_next    = ack_reg;
                        cmd_tail_next  = cmd_head_reg;
                        overflow_next  = 1'b0;
                        full_next      = 1'b0;
                        ready_next     = 1'b0;
                        pending_next   = 1'b0;
                        echo_next      = ECHO_RESET;
                        done_next      = 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
        end

        if (cmd.publish)
        begin
            if (pop_reg)
            begin
                rb_next = ring_rdata;
            end
            pub_hit_next = 1'b0;
            // publish only once every served byte has been acked
            if (served_reg == ack_reg)
            begin
                if (resp_tail_reg != resp_head_reg)
                begin
                    fifo_re        = 1'b1;
                    resp_tail_next = resp_tail_inc;
                    phase_next     = !phase_reg;
                    ready_next     = 1'b1;
                    served_next    = served_reg + 32'd1;
                    pub_hit_next   = 1'b1;
                end
                else
                begin
                    ready_next = 1'b0;
                end
            end
            if (cmd_head_reg == cmd_tail_reg)
            begin
                full_next = 1'b0;
            end
        end

        if (cmd.finish)
        begin
            if (pub_hit_reg)
            begin
                published_next = fifo_rdata;
            end
            out_byte_next = rb_reg;
            out_done_next = done_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            action_reg <= in_action;
            offset_reg <= in_offset;
            data_reg   <= in_data;
        end
        rb_reg       <= rb_next;
        done_reg     <= done_next;
        out_byte_reg <= out_byte_next;
        out_done_reg <= out_done_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_head_reg  <= '0;
            cmd_tail_reg  <= '0;
            resp_head_reg <= '0;
            resp_tail_reg <= '0;
            published_reg <= '0;
            echo_reg      <= ECHO_RESET;
            ack_reg       <= '0;
            served_reg    <= '0;
            pending_reg   <= 1'b0;
            overflow_reg  <= 1'b0;
            full_reg      <= 1'b0;
            ready_reg     <= 1'b0;
            phase_reg     <= 1'b0;
            pub_hit_reg   <= 1'b0;
            pop_reg       <= 1'b0;
        end
        else
        begin
            cmd_head_reg  <= cmd_head_next;
            cmd_tail_reg  <= cmd_tail_next;
            resp_head_reg <= resp_head_next;
            resp_tail_reg <= resp_tail_next;
            published_reg <= published_next;
            echo_reg      <= echo_next;
            ack_reg       <= ack_next;
            served_reg    <= served_next;
            pending_reg   <= pending_next;
            overflow_reg  <= overflow_next;
            full_reg      <= full_next;
            ready_reg     <= ready_next;
            phase_reg     <= phase_next;
            pub_hit_reg   <= pub_hit_next;
            pop_reg       <= pop_next;
        end
    end

endmodule
